// ===== hw/rtl/deqs_pkg.sv =====
// Shared types and constants for the double-ended queue with search.
package deqs_pkg;

    // Ring store depth. Ring positions wrap by truncation, so it must be a power of two.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_POP_BACK   = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value_in;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [4:0]         occupancy;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic pop_load;
        logic scan_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
        logic need_scan;
        logic scan_last;
    } t_dp_status;

endpackage

// ===== hw/rtl/double_ended_queue_with_search_unit.sv =====
// Top level of the double-ended queue with search: controller plus datapath.
//
// The block holds up to 16 signed 32-bit values in a ring store and takes one
// operation per input beat: push or pop at either end, or a search for a value.
// Each input beat yields exactly one output beat carrying a status, the popped
// or matched value, and the occupancy after the operation.
// Both channels use valid and ready; a beat moves on a rising edge with both high.
// One operation is in flight at a time. A push, a refused pop or search, or an
// unused opcode passes through execute and then the hand-over to the output
// register; a pop adds a read step between them, because the ring store has a
// single registered read port. A search reads one stored entry per cycle through
// that port, over every held entry, before the hand-over. The input is ready
// again from the edge that places a result in the output register.
// The output register decouples the two sides: the next beat is accepted and
// worked on while a result still waits; only the hand-over into the output
// register waits for the receiver.
// Synchronous active-low reset empties the queue and clears the output valid;
// the store contents are left as they are, since no held entry survives reset.
module double_ended_queue_with_search_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  deqs_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output deqs_pkg::t_out_beat o_out_data
);
    import deqs_pkg::*;

    // Commands and status between the sequencer and the datapath.
    t_cmd       cmd;
    t_dp_status dp_status;

    // The controller walks each operation through execute, optional read or
    // scan, and the final hand-over to the output register.
    deqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    // The datapath holds the ring store, its front pointer and count, and the
    // result registers.
    deqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

endmodule

// ===== hw/rtl/deqs_dp.sv =====
// Datapath: ring store, pointers, search compare and result registers.
module deqs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deqs_pkg::t_in_beat  i_in_data,
    input  deqs_pkg::t_cmd      i_cmd,
    output deqs_pkg::t_dp_status o_status,
    output deqs_pkg::t_out_beat o_out_data
);
    import deqs_pkg::*;

    logic [31:0]        r_mem [DEPTH];
    logic [2:0]         r_op;
    logic signed [31:0] r_val;
    logic [ADDR_W-1:0]  r_front;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_found;
    logic [31:0]        r_rdata;
    t_out_beat          r_res;
    t_out_beat          r_out;

    logic [ADDR_W-1:0]  n_front;
    logic [CNT_W-1:0]   n_count;
    t_out_beat          n_res;

    logic               is_full;
    logic               is_empty;
    logic [ADDR_W-1:0]  back_addr;
    logic [ADDR_W-1:0]  last_addr;
    logic [ADDR_W-1:0]  front_dec;
    logic [ADDR_W-1:0]  scan_addr;
    logic               match;
    logic               found_n;
    logic               scan_last;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign back_addr = r_front + r_count[ADDR_W-1:0];
    assign last_addr = back_addr - ADDR_W'(1);
    assign front_dec = r_front - ADDR_W'(1);
    assign scan_addr = r_front + r_idx[ADDR_W-1:0];
    assign match     = (r_rdata == r_val);
    assign found_n   = r_found | match;
    assign scan_last = (r_idx == r_count);

    assign o_status.need_read = ((r_op == OP_POP_BACK) || (r_op == OP_POP_FRONT)) && !is_empty;
    assign o_status.need_scan = (r_op == OP_SEARCH) && !is_empty;
    assign o_status.scan_last = scan_last;
    assign o_out_data         = r_out;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = back_addr;
        rd_en   = 1'b0;
        rd_addr = scan_addr;
        n_front = r_front;
        n_count = r_count;
        n_res   = r_res;
        if (i_cmd.exec) begin
            n_res.status    = ST_OK;
            n_res.value_out = '0;
            case (r_op)
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = front_dec;
                        n_front = front_dec;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = last_addr;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_front;
                        n_front = r_front + ADDR_W'(1);
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_SEARCH: begin
                    if (is_empty) begin
                        n_res.status = ST_NOT_FOUND;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_front;
                    end
                end
                default: begin
                end
            endcase
            n_res.occupancy = n_count;
        end
        if (i_cmd.pop_load) begin
            n_res.value_out = r_rdata;
        end
        if (i_cmd.scan_step) begin
            if (scan_last) begin
                n_res.status    = found_n ? ST_OK : ST_NOT_FOUND;
                n_res.value_out = found_n ? r_val : '0;
            end else begin
                rd_en   = 1'b1;
                rd_addr = scan_addr;
            end
        end
    end

    // Ring store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in_data.opcode;
            r_val <= i_in_data.value_in;
        end
        if (i_cmd.exec) begin
            r_idx   <= CNT_W'(1);
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx   <= r_idx + CNT_W'(1);
            r_found <= found_n;
        end
        r_res <= n_res;
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the store depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !is_full && ((r_op == OP_PUSH_BACK) || (r_op == OP_PUSH_FRONT))
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted push did not grow the queue by one");

endmodule

// ===== hw/rtl/deqs_ctrl.sv =====
// Controller: sequences one operation at a time and owns the output valid flag.
module deqs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  deqs_pkg::t_dp_status i_status,
    output deqs_pkg::t_cmd       o_cmd
);
    import deqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.pop_load  = (r_state == S_POP);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.load_out  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_status.need_read) begin
                    n_state = S_POP;
                end else if (i_status.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP:  n_state = S_FIN;
            S_SCAN: if (i_status.scan_last) n_state = S_FIN;
            S_FIN:  if (o_cmd.load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_execs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_EXEC)
        else $error("accepted beat was not executed next cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken output beat");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the double-ended queue with search unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import deqs_pkg::*;

    // The slowest correct run is far below this. It allows for about a thousand beats,
    // each with the longest search, a sender gap and a stalled receiver.
    localparam int CYCLE_LIMIT = 500000;
    // The drain wait at the end is comfortably longer than a search of a full store.
    localparam int DRAIN_CYCLES = 40;

    typedef enum {FILLING, DRAINING, BALANCED} t_bias;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    // While this is set neither side idles, giving one long stretch at full rate.
    bit calm;

    // Predicted queue contents, kept apart from the unit and updated once per
    // accepted input beat.
    logic signed [31:0] deque_store [DEPTH];
    logic [ADDR_W-1:0]  front_slot;
    logic [CNT_W-1:0]   held_count;

    // Results predicted for accepted beats, oldest first.
    t_out_beat pending_results [$];

    int mismatch_count;
    int result_index;
    int cycle_count;

    double_ended_queue_with_search_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock with a 2 ns period: high for one nanosecond, then low for one.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog. A hang anywhere in the unit ends the run here as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver stalls with a chance of about 38 in a hundred, except during the
    // calm stretch. Ready changes on the falling edge, like every other input.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 38);
    end

    // Applies one operation to the predicted queue and returns the result beat that
    // the unit should produce for it. Only held entries are ever read.
    function automatic t_out_beat apply_deque_op(input t_in_beat beat);
        t_out_beat         res;
        logic [ADDR_W-1:0] slot;
        res.status    = ST_OK;
        res.value_out = '0;
        case (beat.opcode)
            OP_PUSH_BACK: begin
                if (held_count == CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    slot = ADDR_W'(front_slot + held_count);
                    deque_store[slot] = beat.value_in;
                    held_count++;
                end
            end
            OP_POP_BACK: begin
                if (held_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_count--;
                    slot = ADDR_W'(front_slot + held_count);
                    res.value_out = deque_store[slot];
                end
            end
            OP_PUSH_FRONT: begin
                if (held_count == CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    front_slot = front_slot - 1'b1;
                    deque_store[front_slot] = beat.value_in;
                    held_count++;
                end
            end
            OP_POP_FRONT: begin
                if (held_count == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value_out = deque_store[front_slot];
                    front_slot = front_slot + 1'b1;
                    held_count--;
                end
            end
            OP_SEARCH: begin
                // Every held entry is looked at; the content is not assumed sorted.
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < held_count; i++) begin
                    slot = ADDR_W'(front_slot + i);
                    if (deque_store[slot] == beat.value_in) begin
                        res.status    = ST_OK;
                        res.value_out = beat.value_in;
                    end
                end
            end
            default: begin
                // Unused opcodes leave everything alone and report ok.
            end
        endcase
        res.occupancy = held_count;
        return res;
    endfunction

    // Sends one input beat. It is entered and left on a falling edge. Valid is only
    // lowered inside a gap, so back-to-back beats never lower and raise it in one step.
    task automatic send_op(input logic [2:0] op, input logic signed [31:0] val);
        t_in_beat beat;
        beat.opcode   = op;
        beat.value_in = val;
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_deque_op(beat));
        @(negedge i_clk);
    endtask

    // Returns a value with a good chance of repeats and of the extremes, so that
    // searches meet duplicates and sign boundaries.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(8)) - 4);
            1: begin
                case ($urandom_range(3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // A search key that is held about half the time when anything is held.
    function automatic logic signed [31:0] pick_search_key();
        logic [ADDR_W-1:0] slot;
        if (held_count != '0 && $urandom_range(1) == 1) begin
            slot = ADDR_W'(front_slot + $urandom_range(held_count - 1));
            return deque_store[slot];
        end
        return pick_value();
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on output beat %0d, %s: expected %0h, got %0h",
                     result_index, field, want, got);
        end
    endtask

    // Each accepted output beat is compared, field by field, with the oldest
    // prediction. A beat with nothing predicted is itself a failure.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Output beat %0d arrived with nothing predicted", result_index);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    report_mismatch("status", want.status, o_out_data.status);
                end
                if (o_out_data.value_out !== want.value_out) begin
                    report_mismatch("value_out", want.value_out, o_out_data.value_out);
                end
                if (o_out_data.occupancy !== want.occupancy) begin
                    report_mismatch("occupancy", want.occupancy, o_out_data.occupancy);
                end
            end
            result_index++;
        end
    end

    // Pops and a search on an empty queue, plus an unused opcode for good measure.
    task automatic test_empty_queue();
        send_op(OP_POP_BACK, 32'h1234_5678);
        send_op(OP_POP_FRONT, 32'hffff_ffff);
        send_op(OP_SEARCH, 32'h0000_0000);
        send_op(3'd7, 32'h8000_0000);
    endtask

    // Extreme values at both ends, found and missing searches, two of the unused
    // opcodes, and pops that empty the queue from both sides.
    task automatic test_extreme_values();
        send_op(OP_PUSH_BACK, 32'h7fff_ffff);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 32'h0000_0000);
        send_op(OP_PUSH_FRONT, 32'hffff_ffff);
        send_op(OP_SEARCH, 32'h8000_0000);
        send_op(OP_SEARCH, 32'h7fff_ffff);
        send_op(OP_SEARCH, 32'h0000_3039);
        send_op(3'd5, 32'h7fff_ffff);
        send_op(3'd6, 32'h5555_aaaa);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
    endtask

    // Fills the store from both ends so that the front wraps, tries a push at each
    // end while full, searches the first and last entries and a missing value, then drains it.
    task automatic test_full_store();
        for (int i = 0; i < DEPTH / 2; i++) begin
            send_op(OP_PUSH_BACK, 32'(100 + i));
            send_op(OP_PUSH_FRONT, 32'(-100 - i));
        end
        send_op(OP_PUSH_BACK, 32'h0bad_0001);
        send_op(OP_PUSH_FRONT, 32'h0bad_0002);
        send_op(OP_SEARCH, 32'(-100 - (DEPTH / 2 - 1)));
        send_op(OP_SEARCH, 32'(100 + (DEPTH / 2 - 1)));
        send_op(OP_SEARCH, 32'h0bad_0001);
        for (int i = 0; i < DEPTH / 2; i++) begin
            send_op(OP_POP_FRONT, $urandom);
            send_op(OP_POP_BACK, $urandom);
        end
    endtask

    // Random traffic in episodes that lean towards filling, draining or neither, so
    // the occupancy sweeps between empty and full many times. One stretch in the
    // middle runs with no idling on either side.
    task automatic test_random_traffic(input int beats);
        t_bias       bias;
        int          roll;
        int          push_cut;
        int          pop_cut;
        logic [2:0]  op;
        logic [31:0] val;
        bias = BALANCED;
        for (int k = 0; k < beats; k++) begin
            calm = (k >= 300 && k < 420);
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: bias = FILLING;
                    1: bias = DRAINING;
                    default: bias = BALANCED;
                endcase
            end
            case (bias)
                FILLING:  begin push_cut = 50; pop_cut = 70; end
                DRAINING: begin push_cut = 20; pop_cut = 70; end
                default:  begin push_cut = 35; pop_cut = 65; end
            endcase
            roll = $urandom_range(99);
            val  = pick_value();
            if (roll < push_cut) begin
                op = ($urandom_range(1) == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else if (roll < pop_cut) begin
                // Pops ignore the value, so it is left fully random.
                op  = ($urandom_range(1) == 1) ? OP_POP_FRONT : OP_POP_BACK;
                val = $urandom;
            end else if (roll < 93) begin
                op  = OP_SEARCH;
                val = pick_search_key();
            end else begin
                op = 3'($urandom_range(7, 5));
            end
            send_op(op, val);
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        calm           = 1'b0;
        front_slot     = '0;
        held_count     = '0;
        mismatch_count = 0;
        result_index   = 0;
        cycle_count    = 0;

        // Reset is asserted from the start and released on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_queue();
        test_extreme_values();
        test_full_store();
        test_random_traffic(750);

        // Stop offering beats, wait for every predicted result, then give the unit
        // time to show any stray beat.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
